>>> hdl/bms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// Shared constants, types and helpers for the bracket match scanner.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int MAX_DEPTH = 255;
    localparam int MAX_LEN   = 65536;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    // count may reach MAX_LEN + 1 on the byte that trips the length check
    localparam int COUNT_W = $clog2(MAX_LEN + 2);

    localparam logic [2:0] ST_MATCH    = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_BADOPEN  = 3'd2;
    localparam logic [2:0] ST_DEPTH    = 3'd3;
    localparam logic [2:0] ST_LONG     = 3'd4;

    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    localparam logic [7:0] LEAD1_LO = 8'h81;
    localparam logic [7:0] LEAD1_HI = 8'h9f;
    localparam logic [7:0] LEAD2_LO = 8'he0;
    localparam logic [7:0] LEAD2_HI = 8'hfc;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [31:0] base_offset;
        logic        last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] end_position;
    } result_t;

    function automatic logic is_lead(input logic [7:0] b);
        is_lead = ((b >= LEAD1_LO) && (b <= LEAD1_HI)) ||
                  ((b >= LEAD2_LO) && (b <= LEAD2_HI));
    endfunction

endpackage

>>> hdl/bms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_in_if / bms_out_if
// Valid/ready channels for text bytes in and scan results out.
// ----------------------------------------------------------------------------
interface bms_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [31:0] base_offset;
    logic        last_byte;

    modport source (output valid, output byte_value, output base_offset,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_value, input base_offset,
                    input last_byte, output ready);
endinterface

interface bms_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] end_position;

    modport source (output valid, output status, output end_position, input ready);
    modport sink   (input valid, input status, input end_position, output ready);
endinterface

>>> hdl/bracket_match_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_match_scanner
// Finds the end of a bracketed span in a byte stream, skipping Shift-JIS
// pairs, strings and comments; one status and end position per text.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | handshake
//  --------+-----+--------------------------------------+------------
//  in_ch   | in  | byte_value, base_offset, last_byte   | valid/ready
//  out_ch  | out | status, end_position                 | valid/ready
//
//  One byte per cycle unless a result byte waits on a stalled out_ch; the byte
//  that causes a result passes the input register, then the result register.
//  The scan state update for a byte is a single combinational step.
//  rst_n clears the scan state and both valid flags; next byte opens a scan.
//  While out_ch stalls, bytes with no result keep flowing; a byte that would
//  produce a result waits in the input register, and in_ch then stalls.
// ----------------------------------------------------------------------------
module bracket_match_scanner (
    input  logic       clk,
    input  logic       rst_n,
    bms_in_if.sink     in_ch,
    bms_out_if.source  out_ch
);

    bms_pkg::item_t    in_item;
    bms_pkg::item_t    stage_item;
    bms_pkg::result_t  core_res;
    logic              stage_valid;
    logic              core_res_valid;
    logic              out_free;
    logic              take;

    assign in_item.byte_value  = in_ch.byte_value;
    assign in_item.base_offset = in_ch.base_offset;
    assign in_item.last_byte   = in_ch.last_byte;

    // a byte with no result never waits for the output side
    assign take = stage_valid && (!core_res_valid || out_free);

    bms_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_item     (in_item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    bms_scan_core u_scan_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .item      (stage_item),
        .res_valid (core_res_valid),
        .res       (core_res)
    );

    bms_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take && core_res_valid),
        .load_res (core_res),
        .free     (out_free),
        .out_ch   (out_ch)
    );

endmodule

>>> hdl/bms_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_in_stage
// Input register: captures one byte transaction and holds it until consumed.
// ----------------------------------------------------------------------------
module bms_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bms_pkg::item_t  in_item,
    input  logic            take,
    output logic            stage_valid,
    output bms_pkg::item_t  stage_item
);

    logic           valid_reg;
    logic           valid_next;
    bms_pkg::item_t item_reg;

    assign in_ready    = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hdl/bms_scan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_scan_core
// Scan state machine: mode, nesting depth, byte count and base. Decides the
// result for the staged byte and updates state when the byte is consumed.
// ----------------------------------------------------------------------------
module bms_scan_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  bms_pkg::item_t    item,
    output logic              res_valid,
    output bms_pkg::result_t  res
);

    localparam logic [2:0] MODE_FIRST  = 3'd0;
    localparam logic [2:0] MODE_NORMAL = 3'd1;
    localparam logic [2:0] MODE_SKIP   = 3'd2;
    localparam logic [2:0] MODE_STRING = 3'd3;
    localparam logic [2:0] MODE_SLASH  = 3'd4;
    localparam logic [2:0] MODE_LINE   = 3'd5;
    localparam logic [2:0] MODE_BLOCK  = 3'd6;

    logic [2:0]                    mode_reg, mode_next;
    logic [bms_pkg::DEPTH_W-1:0]   depth_reg, depth_next;
    logic [bms_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          brace_reg, brace_next;
    logic [31:0]                   base_reg, base_next;
    logic                          star_reg, star_next;
    logic                          sent_reg, sent_next;

    logic                          has_res;
    logic [2:0]                    st;
    logic                          do_normal;
    logic [7:0]                    b;
    logic                          last;
    logic [7:0]                    opener;
    logic [7:0]                    closer;
    logic [bms_pkg::DEPTH_W-1:0]   depth_dec;

    assign b      = item.byte_value;
    assign last   = item.last_byte;
    assign opener = brace_reg ? bms_pkg::CH_LBRACE : bms_pkg::CH_LBRACK;
    assign closer = brace_reg ? bms_pkg::CH_RBRACE : bms_pkg::CH_RBRACK;

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        count_next = count_reg;
        brace_next = brace_reg;
        base_next  = base_reg;
        star_next  = star_reg;
        sent_next  = sent_reg;
        has_res    = 1'b0;
        st         = bms_pkg::ST_NOTFOUND;
        do_normal  = 1'b0;
        depth_dec  = depth_reg;

        if (sent_reg)
        begin
            // drop the tail of a text whose result already went out
            if (last)
            begin
                sent_next = 1'b0;
                mode_next = MODE_FIRST;
            end
        end
        else if (mode_reg == MODE_FIRST)
        begin
            base_next  = item.base_offset;
            count_next = bms_pkg::COUNT_W'(1);
            star_next  = 1'b0;
            if ((b == bms_pkg::CH_LBRACE) || (b == bms_pkg::CH_LBRACK))
            begin
                brace_next = (b == bms_pkg::CH_LBRACE);
                depth_next = bms_pkg::DEPTH_W'(1);
                mode_next  = MODE_NORMAL;
            end
            else
            begin
                has_res = 1'b1;
                st      = bms_pkg::ST_BADOPEN;
            end
        end
        else
        begin
            count_next = count_reg + bms_pkg::COUNT_W'(1);
            if (count_next > bms_pkg::COUNT_W'(bms_pkg::MAX_LEN))
            begin
                has_res = 1'b1;
                st      = bms_pkg::ST_LONG;
            end
            else
            begin
                case (mode_reg)
                    MODE_SKIP:
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    MODE_STRING:
                    begin
                        if ((b == bms_pkg::CH_QUOTE) || (b == bms_pkg::CH_NEWLINE))
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_SLASH:
                    begin
                        if (b == bms_pkg::CH_SLASH)
                        begin
                            mode_next = MODE_LINE;
                        end
                        else if (b == bms_pkg::CH_STAR)
                        begin
                            mode_next = MODE_BLOCK;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            do_normal = 1'b1;
                        end
                    end
                    MODE_LINE:
                    begin
                        if (b == bms_pkg::CH_NEWLINE)
                        begin
                            mode_next = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (star_reg && (b == bms_pkg::CH_SLASH))
                        begin
                            mode_next = MODE_NORMAL;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            star_next = (b == bms_pkg::CH_STAR);
                        end
                    end
                    default:
                    begin
                        do_normal = 1'b1;
                    end
                endcase

                if (do_normal)
                begin
                    mode_next = MODE_NORMAL;
                    if (bms_pkg::is_lead(b))
                    begin
                        // a lead byte at end of text skips nothing
                        if (!last)
                        begin
                            mode_next = MODE_SKIP;
                        end
                    end
                    else if (b == bms_pkg::CH_QUOTE)
                    begin
                        mode_next = MODE_STRING;
                    end
                    else if (b == bms_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (b == opener)
                    begin
                        if (depth_reg >= bms_pkg::DEPTH_W'(bms_pkg::MAX_DEPTH))
                        begin
                            has_res = 1'b1;
                            st      = bms_pkg::ST_DEPTH;
                        end
                        else
                        begin
                            depth_next = depth_reg + bms_pkg::DEPTH_W'(1);
                        end
                    end
                    else if (b == closer)
                    begin
                        if (depth_reg != '0)
                        begin
                            depth_dec = depth_reg - bms_pkg::DEPTH_W'(1);
                        end
                        depth_next = depth_dec;
                        if (depth_dec == '0)
                        begin
                            has_res = 1'b1;
                            st      = bms_pkg::ST_MATCH;
                        end
                    end
                end
            end
        end

        if (!sent_reg && !has_res && last)
        begin
            has_res = 1'b1;
            st      = bms_pkg::ST_NOTFOUND;
        end

        if (has_res)
        begin
            mode_next = MODE_FIRST;
            sent_next = !last;
        end
    end

    assign res_valid        = has_res;
    assign res.status       = st;
    assign res.end_position = (st == bms_pkg::ST_MATCH)
                              ? base_reg + 32'(count_next) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FIRST;
            depth_reg <= '0;
            count_reg <= '0;
            brace_reg <= 1'b0;
            base_reg  <= 32'd0;
            star_reg  <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            count_reg <= count_next;
            brace_reg <= brace_next;
            base_reg  <= base_next;
            star_reg  <= star_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

>>> hdl/bms_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module bms_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  bms_pkg::result_t  load_res,
    output logic              free,
    bms_out_if.source         out_ch
);

    logic              valid_reg;
    logic              valid_next;
    bms_pkg::result_t  res_reg;

    assign free                = !valid_reg || out_ch.ready;
    assign out_ch.valid        = valid_reg;
    assign out_ch.status       = res_reg.status;
    assign out_ch.end_position = res_reg.end_position;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

>>> hdl/bms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_checker
// Port-level checks for the bracket match scanner, bound to the top level.
// ----------------------------------------------------------------------------
module bms_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  out_status,
    input  logic [31:0] out_end_position
);

    // a held result transaction is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status <= bms_pkg::ST_LONG))
    else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != bms_pkg::ST_MATCH) |-> (out_end_position == 32'd0))
    else $error("end position nonzero on a failed scan");

    // with the result register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind bracket_match_scanner bms_checker u_bms_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_end_position (out_ch.end_position)
);
